### rtl/core/rdc_pkg.sv
// Package for the radix digit converter: widths, sizes and shared types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rdc_pkg;

	localparam int VALUE_W     = 63;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CNT_W       = 7;
	localparam int MAX_DIGITS  = 64;
	localparam int MAX_RESULTS = 63;
	localparam int DIGIT_LIMIT = (MAX_DIGITS < MAX_RESULTS) ? MAX_DIGITS : MAX_RESULTS;
	localparam int ADDR_W      = $clog2(MAX_DIGITS);

	localparam int RADIX_MIN = 2;
	localparam int RADIX_MAX = 16;

	// divide unit retires this many dividend bits per cycle
	localparam int BITS_PER_CYCLE = 8;
	localparam int WORK_W  = ((VALUE_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE) * BITS_PER_CYCLE;
	localparam int STEPS   = WORK_W / BITS_PER_CYCLE;
	localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [DIGIT_W-1:0] data;
	} wr_t;

	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] count;
	} emit_cmd_t;

	function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_W'(RADIX_MIN)) res = RADIX_W'(RADIX_MIN);
		if (r > RADIX_W'(RADIX_MAX)) res = RADIX_W'(RADIX_MAX);
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/core/rdc_in_if.sv
// Input channel of the radix digit converter: value and radix per item.
// Depends on rdc_pkg.
`default_nettype none

interface rdc_in_if;
	logic                         valid;
	logic                         ready;
	logic [rdc_pkg::VALUE_W-1:0]  value;
	logic [rdc_pkg::RADIX_W-1:0]  radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

`default_nettype wire

### rtl/core/rdc_out_if.sv
// Output channel of the radix digit converter: one digit and a last flag per item.
// Depends on rdc_pkg.
`default_nettype none

interface rdc_out_if;
	logic                         valid;
	logic                         ready;
	logic [rdc_pkg::DIGIT_W-1:0]  digit;
	logic                         last;

	modport source (output valid, output digit, output last, input ready);
	modport sink   (input valid, input digit, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/rdc_divider.sv
// Repeated division by the radix, BITS_PER_CYCLE quotient bits per cycle.
// Writes each remainder into the digit store; depends on rdc_pkg.
`default_nettype none

module rdc_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rdc_pkg::VALUE_W-1:0]  value,
	input  wire logic [rdc_pkg::RADIX_W-1:0]  radix,
	output rdc_pkg::wr_t                      wr,
	output rdc_pkg::emit_cmd_t                cmd
);

	logic                               busy_q;
	logic [rdc_pkg::WORK_W-1:0]         val_q;
	logic [rdc_pkg::DIGIT_W-1:0]        rem_q;
	logic [rdc_pkg::RADIX_W-1:0]        radix_q;
	logic [rdc_pkg::STEP_W-1:0]         step_q;
	logic [rdc_pkg::CNT_W-1:0]          cnt_q;

	logic [rdc_pkg::RADIX_W-1:0]        trial;
	logic [rdc_pkg::DIGIT_W-1:0]        rem_d;
	logic [rdc_pkg::BITS_PER_CYCLE-1:0] qbits;
	logic [rdc_pkg::WORK_W-1:0]         val_d;
	logic                               digit_end;
	logic                               conv_end;
	logic [rdc_pkg::CNT_W-1:0]          cnt_inc;

	// long division over one slice of the dividend
	always_comb begin
		rem_d = rem_q;
		trial = '0;
		qbits = '0;
		for (int i = 0; i < rdc_pkg::BITS_PER_CYCLE; i++) begin
			trial = {rem_d, val_q[rdc_pkg::WORK_W-1-i]};
			if (trial >= radix_q) begin
				trial = trial - radix_q;
				qbits[rdc_pkg::BITS_PER_CYCLE-1-i] = 1'b1;
			end
			rem_d = trial[rdc_pkg::DIGIT_W-1:0];
		end
	end

	assign val_d     = {val_q[rdc_pkg::WORK_W-rdc_pkg::BITS_PER_CYCLE-1:0], qbits};
	assign digit_end = busy_q && (step_q == rdc_pkg::STEP_W'(rdc_pkg::STEPS - 1));
	assign cnt_inc   = cnt_q + rdc_pkg::CNT_W'(1);
	assign conv_end  = digit_end &&
		((val_d == '0) || (cnt_inc == rdc_pkg::CNT_W'(rdc_pkg::DIGIT_LIMIT)));

	assign wr.we     = digit_end;
	assign wr.addr   = cnt_q[rdc_pkg::ADDR_W-1:0];
	assign wr.data   = rem_d;
	assign cmd.go    = conv_end;
	assign cmd.count = cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			step_q <= step_q + rdc_pkg::STEP_W'(1);
			if (digit_end) begin
				step_q <= '0;
				cnt_q  <= cnt_inc;
				if (conv_end) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q   <= rdc_pkg::WORK_W'(value);
			radix_q <= rdc_pkg::sat_radix(radix);
			rem_q   <= '0;
		end else if (busy_q) begin
			val_q <= val_d;
			// fresh remainder for the next digit
			rem_q <= digit_end ? '0 : rem_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/rdc_digit_buf.sv
// Digit store (synchronous RAM) and the reversed readout into the output register.
// Depends on rdc_pkg and rdc_out_if.
`default_nettype none

module rdc_digit_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rdc_pkg::wr_t       wr,
	input  wire rdc_pkg::emit_cmd_t cmd,
	output logic                    busy,
	rdc_out_if.source               digits
);

	logic [rdc_pkg::DIGIT_W-1:0] mem [rdc_pkg::MAX_DIGITS];

	logic [rdc_pkg::CNT_W-1:0]   rd_left_q;
	logic                        rd_vld_s1;
	logic                        rd_last_s1;
	logic [rdc_pkg::DIGIT_W-1:0] rd_data_s1;
	logic                        out_valid_q;
	logic [rdc_pkg::DIGIT_W-1:0] digit_q;
	logic                        last_q;

	logic                        rd_en;
	logic [rdc_pkg::ADDR_W-1:0]  rd_addr;
	logic [rdc_pkg::CNT_W-1:0]   rd_left_dec;

	assign rd_left_dec = rd_left_q - rdc_pkg::CNT_W'(1);
	assign rd_addr     = rd_left_dec[rdc_pkg::ADDR_W-1:0];
	// read only when the output register is free by the time data lands
	assign rd_en = (rd_left_q != '0) && !rd_vld_s1 && (!out_valid_q || digits.ready);
	assign busy  = (rd_left_q != '0) || rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.addr] <= wr.data;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_last_s1 <= (rd_left_q == rdc_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_left_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.go) rd_left_q <= cmd.count;
			else if (rd_en) rd_left_q <= rd_left_dec;
			rd_vld_s1 <= rd_en;
			if (rd_vld_s1) out_valid_q <= 1'b1;
			else if (digits.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			digit_q <= rd_data_s1;
			last_q  <= rd_last_s1;
		end
	end

	assign digits.valid = out_valid_q;
	assign digits.digit = digit_q;
	assign digits.last  = last_q;

	// store is written only while no readout is pending
	a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !busy) else $error("digit store written during readout");

	// new readout only starts when the previous one is finished
	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> (!busy && cmd.count != '0)) else $error("readout started while busy");

	// read data never overwrites a digit that has not been taken
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (!out_valid_q || digits.ready)) else $error("output digit overwritten");

	// the last flag closes the readout
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && rd_last_s1) |-> (rd_left_q == '0)) else $error("digits left after last");

endmodule

`default_nettype wire

### rtl/core/radix_digit_converter.sv
// Each item gives n digits (1..63); the first digit comes out only after all n are converted.
// A new item is taken only once the last digit of the previous one is in the output register.
// Each digit is made in the divide unit (8 quotient bits per cycle), then read back through the RAM read.
// Worst case is 63 binary digits per item.
// Reset: arst_n clears control state at once; the digit RAM is not cleared.
// Depends on rdc_pkg, rdc_in_if, rdc_out_if, rdc_divider, rdc_digit_buf.
`default_nettype none

module radix_digit_converter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rdc_in_if.sink     operand,
	rdc_out_if.source  digits
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic               accept;
	logic               emit_busy;
	rdc_pkg::wr_t       wr;
	rdc_pkg::emit_cmd_t cmd;

	assign operand.ready = (state_q == S_IDLE);
	assign accept        = operand.valid && operand.ready;

	rdc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (operand.value),
		.radix  (operand.radix),
		.wr     (wr),
		.cmd    (cmd)
	);

	rdc_digit_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.cmd    (cmd),
		.busy   (emit_busy),
		.digits (digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_CONV;
				S_CONV: if (cmd.go) state_q <= S_EMIT;
				// last digit is in the output register: free to take the next item
				S_EMIT: if (!emit_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_go_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> (state_q == S_CONV)) else $error("conversion ended outside S_CONV");

	a_wr_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == S_CONV)) else $error("digit written outside S_CONV");

	a_emit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && cmd.go) |=> emit_busy) else $error("readout did not start");

endmodule

`default_nettype wire
